>>> sv/assert_macros.svh
// assertion macros used by the top-level rtl file, which checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, switched off while reset is low
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, switched off while reset is low
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> sv/dpbt_pkg.sv
// shared types and constants of the depth pixel back-projection core
`default_nettype none

package dpbt_pkg;

    localparam int IMAGE_WIDTH  = 640;
    localparam int IMAGE_HEIGHT = 480;

    localparam int COL_W    = 10;
    localparam int ROW_W    = 9;
    localparam int DEPTH_W  = 16;
    localparam int COLOUR_W = 8;
    localparam int COORD_W  = 20;

    localparam logic [DEPTH_W-1:0] DEPTH_MIN = 16'd41;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'd20480;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 144;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 60;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X      = 4'd0,
        REG_CENTER_Y      = 4'd1,
        REG_INV_FOCAL_X   = 4'd2,
        REG_INV_FOCAL_Y   = 4'd3,
        REG_ROTATION_ROW0 = 4'd4,
        REG_ROTATION_ROW1 = 4'd5,
        REG_ROTATION_ROW2 = 4'd6,
        REG_TRANSLATION   = 4'd7
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [23:0] inv_focal_x;
        logic [23:0] inv_focal_y;
        logic [47:0] rotation_row0;
        logic [47:0] rotation_row1;
        logic [47:0] rotation_row2;
        logic [59:0] translation;
    } t_cfg;

    // classified pixel as it waits in the queue
    typedef struct packed {
        logic                keep;
        logic                du_neg;
        logic [15:0]         du_mag;
        logic                dv_neg;
        logic [15:0]         dv_mag;
        logic [DEPTH_W-1:0]  depth;
        logic [COLOUR_W-1:0] blue;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] red;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic                      point_valid;
        logic signed [COORD_W-1:0] cam_x;
        logic signed [COORD_W-1:0] cam_y;
        logic [DEPTH_W-1:0]        cam_z;
        logic signed [COORD_W-1:0] world_x;
        logic signed [COORD_W-1:0] world_y;
        logic signed [COORD_W-1:0] world_z;
        logic [COLOUR_W-1:0]       out_blue;
        logic [COLOUR_W-1:0]       out_green;
        logic [COLOUR_W-1:0]       out_red;
    } t_point;

endpackage

`default_nettype wire

>>> sv/dpbt_front.sv
// front end: takes pixels, checks range and forms the offsets from the principal point
`default_nettype none

module dpbt_front (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire  [dpbt_pkg::IN_DATA_W-1:0] i_data,
    input  wire  dpbt_pkg::t_cfg       i_cfg,
    input  wire  dpbt_pkg::t_q_stat    i_qstat,
    output logic                       o_push,
    output dpbt_pkg::t_item            o_item
);
    import dpbt_pkg::*;

    logic        r_vld;
    logic        n_vld;
    t_item       r_item;
    t_item       n_item;

    logic [COL_W-1:0]   w_col;
    logic [ROW_W-1:0]   w_row;
    logic [DEPTH_W-1:0] w_depth;
    logic signed [16:0] w_du;
    logic signed [16:0] w_dv;
    logic               w_in_image;
    logic               w_in_range;
    logic               w_take;

    assign w_col   = i_data[9:0];
    assign w_row   = i_data[18:10];
    assign w_depth = i_data[34:19];

    assign o_push  = r_vld && !i_qstat.full;
    assign o_ready = !r_vld || !i_qstat.full;
    assign o_item  = r_item;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        w_in_image = (int'(w_col) < IMAGE_WIDTH) && (int'(w_row) < IMAGE_HEIGHT);
        w_in_range = (w_depth >= DEPTH_MIN) && (w_depth <= DEPTH_MAX);
        w_du = $signed({3'b000, w_col, 4'b0000}) - $signed({1'b0, i_cfg.center_x});
        w_dv = $signed({4'b0000, w_row, 4'b0000}) - $signed({1'b0, i_cfg.center_y});

        n_item.keep   = w_in_image && w_in_range;
        n_item.du_neg = w_du[16];
        n_item.du_mag = w_du[16] ? 16'(17'd0 - w_du) : w_du[15:0];
        n_item.dv_neg = w_dv[16];
        n_item.dv_mag = w_dv[16] ? 16'(17'd0 - w_dv) : w_dv[15:0];
        n_item.depth  = w_depth;
        n_item.blue   = i_data[42:35];
        n_item.green  = i_data[50:43];
        n_item.red    = i_data[58:51];
    end

    always_comb begin
        n_vld = r_vld;
        if (w_take) begin
            n_vld = 1'b1;
        end else if (o_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

>>> sv/dpbt_queue.sv
// short queue between the front end and the arithmetic pipeline
`default_nettype none

module dpbt_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  wire  dpbt_pkg::t_item   i_item,
    input  wire                     i_pop,
    output dpbt_pkg::t_item         o_item,
    output dpbt_pkg::t_q_stat       o_stat
);
    import dpbt_pkg::*;

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;

    assign o_item       = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = QCNT_W'(r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop));
        if (i_push) begin
            n_wr = (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(r_wr + 1'b1);
        end
        if (i_pop) begin
            n_rd = (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(r_rd + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> sv/dpbt_back.sv
// arithmetic pipeline: camera back-projection, pose transform and output register
`default_nettype none

module dpbt_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire  dpbt_pkg::t_cfg    i_cfg,
    input  wire  dpbt_pkg::t_q_stat i_qstat,
    input  wire  dpbt_pkg::t_item   i_item,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire                     i_ready,
    output dpbt_pkg::t_point        o_point
);
    import dpbt_pkg::*;

    typedef struct packed {
        logic                keep;
        logic [DEPTH_W-1:0]  depth;
        logic [COLOUR_W-1:0] blue;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] red;
    } t_side;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [DEPTH_W-1:0]        cz;
    } t_cam;

    // rounds a 2^-40 m magnitude to 1/4096 m, ties away from zero, and saturates
    function automatic logic signed [COORD_W-1:0] cam_sat(logic [55:0] mag, logic neg);
        logic [55:0] sum;
        logic [28:0] r;
        logic [28:0] nr;
        sum = mag + 56'd134217728;
        r   = {1'b0, sum[56-1:28]};
        nr  = 29'd0 - r;
        if (neg) begin
            return (r > 29'd524288) ? -20'sd524288 : $signed(nr[COORD_W-1:0]);
        end
        return (r > 29'd524287) ? 20'sd524287 : $signed(r[COORD_W-1:0]);
    endfunction

    function automatic logic signed [35:0] mul_sc(logic signed [15:0] c,
                                                  logic signed [COORD_W-1:0] v);
        logic signed [35:0] a;
        logic signed [35:0] b;
        a = {{20{c[15]}}, c};
        b = {{16{v[COORD_W-1]}}, v};
        return a * b;
    endfunction

    logic w_en;

    // stage 1: offset times depth
    logic        r1_vld;
    logic [31:0] r1_px;
    logic [31:0] r1_py;
    logic        r1_xneg;
    logic        r1_yneg;
    t_side       r1_sd;
    // stage 2: times reciprocal focal length
    logic        r2_vld;
    logic [55:0] r2_px;
    logic [55:0] r2_py;
    logic        r2_xneg;
    logic        r2_yneg;
    t_side       r2_sd;
    // stage 3: camera coordinates
    logic        r3_vld;
    t_cam        r3_cam;
    t_side       r3_sd;
    // stage 4: rotation products
    logic               r4_vld;
    logic signed [35:0] r4_p [3][3];
    t_cam               r4_cam;
    t_side              r4_sd;
    // stage 5: row sums
    logic               r5_vld;
    logic signed [37:0] r5_s [3];
    t_cam               r5_cam;
    t_side              r5_sd;
    // stage 6: rounded rows
    logic               r6_vld;
    logic signed [23:0] r6_rnd [3];
    t_cam               r6_cam;
    t_side              r6_sd;
    // output register
    logic               r_o_vld;
    t_point             r_o_pt;

    logic [47:0]               w_rot [3];
    logic signed [15:0]        w_coef [3][3];
    logic signed [COORD_W-1:0] w_t [3];
    logic signed [COORD_W-1:0] w_z20;
    logic signed [24:0]        w_w [3];
    logic signed [COORD_W-1:0] w_wsat [3];
    logic signed [37:0]        w_rsum [3];

    assign w_en    = !r_o_vld || i_ready;
    assign o_pop   = w_en && !i_qstat.empty;
    assign o_valid = r_o_vld;
    assign o_point = r_o_pt;

    assign w_rot[0] = i_cfg.rotation_row0;
    assign w_rot[1] = i_cfg.rotation_row1;
    assign w_rot[2] = i_cfg.rotation_row2;
    assign w_z20    = $signed({4'b0000, r3_cam.cz});

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_t[r] = $signed(i_cfg.translation[20*r +: 20]);
            for (int e = 0; e < 3; e++) begin
                w_coef[r][e] = $signed(w_rot[r][16*e +: 16]);
            end
            // ties away from zero in one add: bias is one less for negative sums
            w_rsum[r] = r5_s[r] + (r5_s[r][37] ? 38'sd8191 : 38'sd8192);
            w_w[r]    = {r6_rnd[r][23], r6_rnd[r]} + {{5{w_t[r][COORD_W-1]}}, w_t[r]};
            if (w_w[r] > 25'sd524287) begin
                w_wsat[r] = 20'sd524287;
            end else if (w_w[r] < -25'sd524288) begin
                w_wsat[r] = -20'sd524288;
            end else begin
                w_wsat[r] = w_w[r][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld  <= o_pop;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
            r5_vld  <= r4_vld;
            r6_vld  <= r5_vld;
            r_o_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_px       <= {16'd0, i_item.du_mag} * {16'd0, i_item.depth};
            r1_py       <= {16'd0, i_item.dv_mag} * {16'd0, i_item.depth};
            r1_xneg     <= i_item.du_neg;
            r1_yneg     <= i_item.dv_neg;
            r1_sd.keep  <= i_item.keep;
            r1_sd.depth <= i_item.depth;
            r1_sd.blue  <= i_item.blue;
            r1_sd.green <= i_item.green;
            r1_sd.red   <= i_item.red;

            r2_px   <= 56'(r1_px) * 56'(i_cfg.inv_focal_x);
            r2_py   <= 56'(r1_py) * 56'(i_cfg.inv_focal_y);
            r2_xneg <= r1_xneg;
            r2_yneg <= r1_yneg;
            r2_sd   <= r1_sd;

            // rejected pixels carry zero camera coordinates from here on
            r3_cam.cx <= r2_sd.keep ? cam_sat(r2_px, r2_xneg) : '0;
            r3_cam.cy <= r2_sd.keep ? cam_sat(r2_py, r2_yneg) : '0;
            r3_cam.cz <= r2_sd.keep ? r2_sd.depth : '0;
            r3_sd     <= r2_sd;

            for (int r = 0; r < 3; r++) begin
                r4_p[r][0] <= mul_sc(w_coef[r][0], r3_cam.cx);
                r4_p[r][1] <= mul_sc(w_coef[r][1], r3_cam.cy);
                r4_p[r][2] <= mul_sc(w_coef[r][2], w_z20);
            end
            r4_cam <= r3_cam;
            r4_sd  <= r3_sd;

            for (int r = 0; r < 3; r++) begin
                r5_s[r] <= 38'(r4_p[r][0]) + 38'(r4_p[r][1]) + 38'(r4_p[r][2]);
            end
            r5_cam <= r4_cam;
            r5_sd  <= r4_sd;

            for (int r = 0; r < 3; r++) begin
                r6_rnd[r] <= w_rsum[r][37:14];
            end
            r6_cam <= r5_cam;
            r6_sd  <= r5_sd;

            r_o_pt.point_valid <= r6_sd.keep;
            r_o_pt.cam_x       <= r6_cam.cx;
            r_o_pt.cam_y       <= r6_cam.cy;
            r_o_pt.cam_z       <= r6_cam.cz;
            r_o_pt.world_x     <= r6_sd.keep ? w_wsat[0] : '0;
            r_o_pt.world_y     <= r6_sd.keep ? w_wsat[1] : '0;
            r_o_pt.world_z     <= r6_sd.keep ? w_wsat[2] : '0;
            r_o_pt.out_blue    <= r6_sd.blue;
            r_o_pt.out_green   <= r6_sd.green;
            r_o_pt.out_red     <= r6_sd.red;
        end
    end

endmodule

`default_nettype wire

>>> sv/depth_pixel_backproject_transform_core.sv
// top level of the depth pixel back-projection and pose transform core
//
//   channel   | direction | handshake                   | contents
//   s_axis    | in        | tvalid / tready             | one depth pixel with colour
//   m_axis    | out       | tvalid / tready             | camera and world point, colour
//   cfg       | in        | i_cfg_valid / o_cfg_ready   | register index and write data
//
// one pixel per clock sustained while m_axis accepts; a pixel from s_axis reaches m_axis through
// the front register, the queue, six arithmetic stages and the output register
// the camera product runs through two multiplier stages, the pose through one more
// reset returns the intrinsics and pose to their defaults and empties the queue
// a stalled m_axis freezes the arithmetic pipeline; the four-entry queue keeps
// s_axis flowing until it fills
`default_nettype none

`include "assert_macros.svh"

module depth_pixel_backproject_transform_core (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // column[9:0] row[18:10] depth[34:19] blue[42:35] green[50:43] red[58:51]
    input  wire  [dpbt_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  wire                                  i_m_axis_tready,
    // cam_x[19:0] cam_y[39:20] cam_z[55:40] world_x[75:56] world_y[95:76]
    // world_z[115:96] out_blue[123:116] out_green[131:124] out_red[139:132]
    output logic [dpbt_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // point_valid[0]
    output logic                                 o_m_axis_tuser,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [dpbt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [dpbt_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import dpbt_pkg::*;

    t_cfg    r_cfg;
    t_cfg    n_cfg;
    t_item   w_front_item;
    t_item   w_queue_item;
    t_q_stat w_qstat;
    t_point  w_point;
    logic    w_push;
    logic    w_pop;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CENTER_X:      n_cfg.center_x      = i_cfg_data[15:0];
                REG_CENTER_Y:      n_cfg.center_y      = i_cfg_data[15:0];
                REG_INV_FOCAL_X:   n_cfg.inv_focal_x   = i_cfg_data[23:0];
                REG_INV_FOCAL_Y:   n_cfg.inv_focal_y   = i_cfg_data[23:0];
                REG_ROTATION_ROW0: n_cfg.rotation_row0 = i_cfg_data[47:0];
                REG_ROTATION_ROW1: n_cfg.rotation_row1 = i_cfg_data[47:0];
                REG_ROTATION_ROW2: n_cfg.rotation_row2 = i_cfg_data[47:0];
                REG_TRANSLATION:   n_cfg.translation   = i_cfg_data[59:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x      <= 16'd5120;
            r_cfg.center_y      <= 16'd3840;
            r_cfg.inv_focal_x   <= 24'd31957;
            r_cfg.inv_focal_y   <= 24'd31957;
            r_cfg.rotation_row0 <= 48'h0000_0000_4000;
            r_cfg.rotation_row1 <= 48'h0000_4000_0000;
            r_cfg.rotation_row2 <= 48'h4000_0000_0000;
            r_cfg.translation   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    dpbt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .i_cfg   (r_cfg),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_item  (w_front_item)
    );

    dpbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_queue_item),
        .o_stat  (w_qstat)
    );

    dpbt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_qstat (w_qstat),
        .i_item  (w_queue_item),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_point (w_point)
    );

    assign o_m_axis_tuser = w_point.point_valid;
    assign o_m_axis_tdata = {4'b0000,
                             w_point.out_red,
                             w_point.out_green,
                             w_point.out_blue,
                             w_point.world_z,
                             w_point.world_y,
                             w_point.world_x,
                             w_point.cam_z,
                             w_point.cam_y,
                             w_point.cam_x};

    // rejected pixels leave with all coordinates cleared
    `ASSERT_IMP(a_reject_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tdata[115:0] == '0)
    // a kept point carries a depth inside the accepted window
    `ASSERT_IMP(a_kept_depth, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser,
        (o_m_axis_tdata[55:40] >= DEPTH_MIN) && (o_m_axis_tdata[55:40] <= DEPTH_MAX))
    // the front end never pushes into a full queue
    `ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, w_push, !w_qstat.full)
    // the arithmetic side never pops an empty queue
    `ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, w_pop, !w_qstat.empty)
    // a translation write lands in the pose register
    `ASSERT_NXT(a_trans_write, i_clk, i_rst_n,
        i_cfg_valid && (i_cfg_index == REG_TRANSLATION),
        r_cfg.translation == $past(i_cfg_data))

endmodule

`default_nettype wire
